/* src/xcr_pkg.sv */
// ---------------------------------------------------------------------------
// xcr_pkg: shared definitions for the xmodem checksum receiver
// Control codes, command and status codes, result record and queue sizing.
// ---------------------------------------------------------------------------
package xcr_pkg;

    // frame geometry
    localparam int BLOCK_BYTES = 128;
    localparam int FP_W        = 11;
    localparam int ADDR_W      = 23;

    // result queue sizing
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // configuration port
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam logic REG_MAX_BLOCKS  = 1'b0;
    localparam logic REG_MAX_RETRIES = 1'b1;

    // commands
    localparam logic [1:0] CMD_START   = 2'd0;
    localparam logic [1:0] CMD_BYTE    = 2'd1;
    localparam logic [1:0] CMD_TIMEOUT = 2'd2;

    // line control characters
    localparam logic [7:0] CH_SOH  = 8'h01;
    localparam logic [7:0] CH_CTLC = 8'h03;
    localparam logic [7:0] CH_EOT  = 8'h04;
    localparam logic [7:0] CH_ACK  = 8'h06;
    localparam logic [7:0] CH_NAK  = 8'h15;
    localparam logic [7:0] CH_CAN  = 8'h18;
    localparam logic [7:0] CH_ONES = 8'hFF;

    // session phase
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_WAIT  = 2'd1;
    localparam logic [1:0] PH_FRAME = 2'd2;

    // session status
    localparam logic [1:0] ST_RUN   = 2'd0;
    localparam logic [1:0] ST_OK    = 2'd1;
    localparam logic [1:0] ST_ABORT = 2'd2;
    localparam logic [1:0] ST_BAD   = 2'd3;

    // one result beat
    typedef struct packed {
        logic              reply_valid;
        logic [7:0]        reply_byte;
        logic              write_valid;
        logic [ADDR_W-1:0] write_address;
        logic [7:0]        write_data;
        logic [1:0]        session_status;
        logic [15:0]       blocks_received;
        logic              last_result;
    } t_result;

    // reply beat with no write
    function automatic t_result mk_reply(input logic [7:0] ch, input logic [1:0] st,
                                         input logic [15:0] blk);
        t_result r;
        r                 = '0;
        r.reply_valid     = 1'b1;
        r.reply_byte      = ch;
        r.session_status  = st;
        r.blocks_received = blk;
        return r;
    endfunction

endpackage

/* src/xcr_in_if.sv */
// ---------------------------------------------------------------------------
// xcr_in_if: input event channel
// Valid/ready channel carrying one command and received byte per beat.
// ---------------------------------------------------------------------------
interface xcr_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] rx_byte;

    modport source (output valid, command, rx_byte, input ready);
    modport sink   (input valid, command, rx_byte, output ready);
endinterface

/* src/xcr_out_if.sv */
// ---------------------------------------------------------------------------
// xcr_out_if: result channel
// Valid/ready channel carrying one reply or data write per beat.
// ---------------------------------------------------------------------------
interface xcr_out_if;
    logic        valid;
    logic        ready;
    logic        reply_valid;
    logic [7:0]  reply_byte;
    logic        write_valid;
    logic [22:0] write_address;
    logic [7:0]  write_data;
    logic [1:0]  session_status;
    logic [15:0] blocks_received;
    logic        last_result;

    modport source (output valid, reply_valid, reply_byte, write_valid, write_address,
                    write_data, session_status, blocks_received, last_result,
                    input ready);
    modport sink   (input valid, reply_valid, reply_byte, write_valid, write_address,
                    write_data, session_status, blocks_received, last_result,
                    output ready);
endinterface

/* src/xmodem_checksum_receiver_top.sv */
// ---------------------------------------------------------------------------
// xmodem_checksum_receiver_top: xmodem receiver, 8-bit checksum
// Frame assembly, data write generation, ACK/NAK/CAN replies and session
// status, with an APB register port for buffer size and retry limit.
// ---------------------------------------------------------------------------
//  channel   dir   handshake            payload
//  i_in      in    valid/ready          command, rx_byte
//  o_out     out   valid/ready          reply, data write, status, last flag
//  apb       in    psel/penable/pready  max_blocks @0x0, max_retries @0x4
//
//  An event is decoded in the cycle it is accepted and its zero, one or two
//  results land in a four-entry result queue; the next event is taken in the
//  following cycle, so one event per cycle is sustained while ready is high.
//  ready drops only while the queue has fewer than two free entries.
//  Reset is synchronous: session idle, expected block one, queue empty,
//  registers back to 512 blocks and 10 retries.
// ---------------------------------------------------------------------------
module xmodem_checksum_receiver_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    xcr_in_if.sink                       i_in,
    xcr_out_if.source                    o_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [xcr_pkg::PADDR_W-1:0]  paddr,
    input  logic [xcr_pkg::PDATA_W-1:0]  pwdata,
    output logic [xcr_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);
    import xcr_pkg::*;

    // configuration registers
    logic [15:0] r_max_blocks;
    logic [7:0]  r_max_retries;

    // session state
    logic [1:0]      r_phase,    n_phase;
    logic [FP_W-1:0] r_fpos,     n_fpos;
    logic [16:0]     r_exp,      n_exp;
    logic [7:0]      r_retry,    n_retry;
    logic [7:0]      r_seq,      n_seq;
    logic [7:0]      r_seq_cpl,  n_seq_cpl;
    logic [7:0]      r_sum,      n_sum;

    // result queue
    t_result           r_queue [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_cnt;

    logic        in_fire, out_fire;
    logic [1:0]  n_res;
    t_result     res0, res1;
    logic        attempt;
    logic [7:0]  cur, prev;
    logic        hdr_ok;
    logic [16:0] exp_m1;
    logic [ADDR_W-1:0] waddr;

    // apb register port
    assign pready = 1'b1;

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_MAX_RETRIES) begin
            prdata[7:0] = r_max_retries;
        end else begin
            prdata[15:0] = r_max_blocks;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_blocks  <= 16'd512;
            r_max_retries <= 8'd10;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_MAX_RETRIES) begin
                r_max_retries <= pwdata[7:0];
            end else begin
                r_max_blocks <= pwdata[15:0];
            end
        end
    end

    // handshakes
    assign i_in.ready = (r_cnt <= QCNT_W'(QUEUE_DEPTH - 2));
    assign in_fire    = i_in.valid && i_in.ready;
    assign out_fire   = o_out.valid && o_out.ready;

    // header and address helpers
    assign cur    = r_exp[7:0];
    assign exp_m1 = r_exp - 17'd1;
    assign prev   = exp_m1[7:0];
    assign hdr_ok = (r_seq == cur) && (r_seq_cpl == (CH_ONES - cur));
    assign waddr  = ADDR_W'(exp_m1) * ADDR_W'(BLOCK_BYTES)
                  + ADDR_W'(r_fpos - FP_W'(3));

    // event decode
    always_comb begin
        n_phase   = r_phase;
        n_fpos    = r_fpos;
        n_exp     = r_exp;
        n_retry   = r_retry;
        n_seq     = r_seq;
        n_seq_cpl = r_seq_cpl;
        n_sum     = r_sum;
        n_res     = 2'd0;
        res0      = '0;
        res1      = '0;
        attempt   = 1'b0;

        if (in_fire) begin
            if (i_in.command == CMD_START) begin
                n_exp   = 17'd1;
                n_retry = '0;
                n_fpos  = '0;
                res0    = mk_reply(CH_NAK, ST_RUN, 16'd0);
                n_res   = 2'd1;
                attempt = 1'b1;
            end else if (i_in.command == CMD_BYTE || i_in.command == CMD_TIMEOUT) begin
                if (r_phase == PH_WAIT) begin
                    if (i_in.command == CMD_TIMEOUT) begin
                        res0    = mk_reply(CH_NAK, ST_RUN, 16'd0);
                        n_res   = 2'd1;
                        attempt = 1'b1;
                    end else begin
                        case (i_in.rx_byte)
                            CH_SOH: begin
                                n_phase   = PH_FRAME;
                                n_fpos    = FP_W'(1);
                                n_retry   = '0;
                                n_sum     = '0;
                                n_seq     = '0;
                                n_seq_cpl = '0;
                            end
                            CH_CAN: begin
                                n_phase = PH_IDLE;
                                res0    = mk_reply(CH_ACK, ST_ABORT, 16'd0);
                                n_res   = 2'd1;
                            end
                            CH_CTLC: begin
                                n_phase = PH_IDLE;
                                res0    = mk_reply(CH_CAN, ST_ABORT, 16'd0);
                                n_res   = 2'd1;
                            end
                            CH_EOT: begin
                                n_phase = PH_IDLE;
                                res0    = mk_reply(CH_ACK, ST_OK, exp_m1[15:0]);
                                n_res   = 2'd1;
                            end
                            default: begin
                                res0    = mk_reply(CH_NAK, ST_RUN, 16'd0);
                                n_res   = 2'd1;
                                attempt = 1'b1;
                            end
                        endcase
                    end
                end else if (r_phase == PH_FRAME) begin
                    if (i_in.command == CMD_TIMEOUT) begin
                        // frame dropped
                        n_fpos  = '0;
                        res0    = mk_reply(CH_NAK, ST_RUN, 16'd0);
                        n_res   = 2'd1;
                        attempt = 1'b1;
                    end else if (r_fpos == FP_W'(1)) begin
                        n_seq  = i_in.rx_byte;
                        n_fpos = FP_W'(2);
                    end else if (r_fpos == FP_W'(2)) begin
                        n_seq_cpl = i_in.rx_byte;
                        n_fpos    = FP_W'(3);
                    end else if (r_fpos < FP_W'(BLOCK_BYTES + 3)) begin
                        // data byte: sum it and store it if the header names this block
                        n_sum  = r_sum + i_in.rx_byte;
                        n_fpos = r_fpos + FP_W'(1);
                        if (hdr_ok) begin
                            res0.write_valid   = 1'b1;
                            res0.write_address = waddr;
                            res0.write_data    = i_in.rx_byte;
                            n_res              = 2'd1;
                        end
                    end else begin
                        // checksum byte closes the frame
                        n_fpos = '0;
                        n_res  = 2'd1;
                        if (r_seq == prev) begin
                            res0 = mk_reply(CH_ACK, ST_RUN, 16'd0);
                        end else if (!hdr_ok || r_sum != i_in.rx_byte) begin
                            res0 = mk_reply(CH_NAK, ST_RUN, 16'd0);
                        end else begin
                            n_retry = '0;
                            n_exp   = r_exp + 17'd1;
                            res0    = mk_reply(CH_ACK, ST_RUN, 16'd0);
                        end
                        attempt = 1'b1;
                    end
                end
            end
        end

        // attempt end: cancel on full buffer or exhausted retries
        if (attempt) begin
            if (n_exp > {1'b0, r_max_blocks} || n_retry >= r_max_retries) begin
                n_phase = PH_IDLE;
                res1    = mk_reply(CH_CAN, ST_BAD, 16'd0);
                n_res   = 2'd2;
            end else begin
                n_retry = n_retry + 8'd1;
                n_phase = PH_WAIT;
            end
        end

        // mark the final result of this event
        if (n_res == 2'd2) begin
            res1.last_result = 1'b1;
        end else begin
            res0.last_result = 1'b1;
        end
    end

    // session state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_fpos    <= '0;
            r_exp     <= 17'd1;
            r_retry   <= '0;
            r_seq     <= '0;
            r_seq_cpl <= '0;
            r_sum     <= '0;
        end else begin
            r_phase   <= n_phase;
            r_fpos    <= n_fpos;
            r_exp     <= n_exp;
            r_retry   <= n_retry;
            r_seq     <= n_seq;
            r_seq_cpl <= n_seq_cpl;
            r_sum     <= n_sum;
        end
    end

    // result queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + QPTR_W'(n_res);
            r_rd  <= r_rd + QPTR_W'(out_fire);
            r_cnt <= r_cnt + QCNT_W'(n_res) - QCNT_W'(out_fire);
        end
    end

    // result queue storage
    always_ff @(posedge i_clk) begin
        if (n_res != 2'd0) begin
            r_queue[r_wr] <= res0;
        end
        if (n_res == 2'd2) begin
            r_queue[r_wr + QPTR_W'(1)] <= res1;
        end
    end

    // result beat
    assign o_out.valid           = (r_cnt != '0);
    assign o_out.reply_valid     = r_queue[r_rd].reply_valid;
    assign o_out.reply_byte      = r_queue[r_rd].reply_byte;
    assign o_out.write_valid     = r_queue[r_rd].write_valid;
    assign o_out.write_address   = r_queue[r_rd].write_address;
    assign o_out.write_data      = r_queue[r_rd].write_data;
    assign o_out.session_status  = r_queue[r_rd].session_status;
    assign o_out.blocks_received = r_queue[r_rd].blocks_received;
    assign o_out.last_result     = r_queue[r_rd].last_result;

endmodule
